// ----- rtl/core/sst_pkg.sv -----
// Shared types and constants for the sorted set table.
package sst_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } op_e;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ----- rtl/core/sorted_set_table.sv -----
// Top level of the sorted set table: a chain of entry cells and its control.
//
// Holds a set of distinct items in ascending order, one item per cell.
// Input channel (in_valid_i / in_stall_o) carries op_i, value_i, index_i:
// insert, erase, contains, or get by rank. Output channel
// (out_valid_o / out_stall_i) carries ok_o, item_out_o and item_count_o,
// exactly one result transaction per input transaction.
// A transaction is captured at acceptance; once the output register is free,
// every cell compares its entry with the item at once and shifts toward or
// away from its neighbor, and the result lands in the output register. The
// input stalls from capture until that compare-and-shift step executes, so a
// new item is taken only after the last one has executed.
// A waiting result does not block the next acceptance. While the receiver
// stalls, the result holds and a captured item waits for the output
// register to free before it executes.
// cfg_we_i writes the capacity limit max_q (reset 64).
// Reset empties the set; cell contents are not cleared, and only ranks
// below the count are ever read.
module sorted_set_table #(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sst_pkg::COUNT_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sst_pkg::OP_W-1:0]      op_i,
  input  logic [sst_pkg::VALUE_W-1:0]   value_i,
  input  logic [sst_pkg::INDEX_W-1:0]   index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [sst_pkg::VALUE_W-1:0]   item_out_o,
  output logic [sst_pkg::COUNT_W-1:0]   item_count_o
);

  localparam int VW = sst_pkg::VALUE_W;
  localparam int NW = sst_pkg::COUNT_W;
  localparam int IW = sst_pkg::INDEX_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > NW) ? CW : NW;
  localparam int XW = (ITEM_WIDTH > VW) ? ITEM_WIDTH : VW;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                 state_q;
  sst_pkg::op_e           op_q;
  logic [ITEM_WIDTH-1:0]  val_q;
  logic [IW-1:0]          idx_q;
  logic [NW-1:0]          max_q;
  logic [CW-1:0]          cnt_q;
  logic [CW-1:0]          cnt_d;
  logic                   out_valid_q;
  logic                   ok_q;
  logic                   ok_d;
  logic [VW-1:0]          item_q;
  logic [VW-1:0]          item_d;
  logic [NW-1:0]          cnt_out_q;

  logic [XW-1:0]          val_ext;
  logic [LW-1:0]          cnt_ext;
  logic                   room;
  logic                   found;
  logic                   rank_ok;
  logic                   exec;
  logic [ITEM_WIDTH-1:0]  rd_any;
  sst_pkg::cell_ctl_t     ctl;

  logic [ITEM_WIDTH-1:0]  ent [CAPACITY];
  logic [ITEM_WIDTH-1:0]  rd  [CAPACITY];
  logic [CAPACITY-1:0]    lt;
  logic [CAPACITY-1:0]    eq;

  assign in_stall_o = (state_q != ST_IDLE);
  assign exec       = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign val_ext    = XW'(value_i);
  assign cnt_ext    = LW'(cnt_q);

  assign room    = (cnt_ext < LW'(max_q)) && (cnt_ext < LW'(CAPACITY));
  assign found   = |eq;
  assign rank_ok = LW'(idx_q) < cnt_ext;

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd[k];
    end
  end

  always_comb begin
    ctl.ins = 1'b0;
    ctl.del = 1'b0;
    ok_d    = 1'b0;
    item_d  = '0;
    cnt_d   = cnt_q;
    unique case (op_q)
      sst_pkg::OP_INSERT: begin
        ok_d    = room && !found;
        ctl.ins = exec && ok_d;
        if (ok_d) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      sst_pkg::OP_ERASE: begin
        ok_d    = found;
        ctl.del = exec && found;
        if (found) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      sst_pkg::OP_CONTAINS: begin
        ok_d = found;
      end
      sst_pkg::OP_GET: begin
        ok_d = rank_ok;
        if (rank_ok) begin
          item_d = VW'(XW'(rd_any));
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                  prev_lt;
    logic [ITEM_WIDTH-1:0] prev_ent;
    logic [ITEM_WIDTH-1:0] next_ent;

    if (k == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_ent = '0;
    end else begin : g_mid
      assign prev_lt  = lt[k-1];
      assign prev_ent = ent[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ent[k+1];
    end

    sst_cell #(
      .W  (ITEM_WIDTH),
      .CW (CW),
      .K  (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .val_i      (val_q),
      .cnt_i      (cnt_q),
      .idx_i      (idx_q),
      .prev_lt_i  (prev_lt),
      .prev_ent_i (prev_ent),
      .next_ent_i (next_ent),
      .ent_o      (ent[k]),
      .lt_o       (lt[k]),
      .eq_o       (eq[k]),
      .rd_o       (rd[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      max_q       <= NW'(64);
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      item_q      <= '0;
      cnt_out_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        ok_q        <= ok_d;
        item_q      <= item_d;
        cnt_out_q   <= NW'(cnt_d);
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec) begin
            state_q <= ST_IDLE;
            cnt_q   <= cnt_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      op_q  <= sst_pkg::op_e'(op_i);
      val_q <= val_ext[ITEM_WIDTH-1:0];
      idx_q <= index_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign item_out_o   = item_q;
  assign item_count_o = cnt_out_q;

endmodule

// ----- rtl/core/sst_cell.sv -----
// One table entry: compare against the lookup item and shift with its neighbors.
module sst_cell #(
  parameter int W  = 32,
  parameter int CW = 7,
  parameter int K  = 0
) (
  input  logic                          clk_i,
  input  sst_pkg::cell_ctl_t            ctl_i,
  input  logic [W-1:0]                  val_i,
  input  logic [CW-1:0]                 cnt_i,
  input  logic [sst_pkg::INDEX_W-1:0]   idx_i,
  input  logic                          prev_lt_i,
  input  logic [W-1:0]                  prev_ent_i,
  input  logic [W-1:0]                  next_ent_i,
  output logic [W-1:0]                  ent_o,
  output logic                          lt_o,
  output logic                          eq_o,
  output logic [W-1:0]                  rd_o
);

  localparam int  IW     = sst_pkg::INDEX_W;
  localparam bit  IN_IDX = K < (2 ** IW);

  logic [W-1:0] ent_q;
  logic [W-1:0] ent_d;
  logic         used;
  logic         sel;

  assign used  = CW'(K) < cnt_i;
  assign lt_o  = used && (ent_q < val_i);
  assign eq_o  = used && (ent_q == val_i);
  assign sel   = IN_IDX && used && (IW'(K) == idx_i);
  assign rd_o  = sel ? ent_q : '0;
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.ins && !lt_o) begin
      ent_d = prev_lt_i ? val_i : prev_ent_i;
    end else if (ctl_i.del && !lt_o) begin
      ent_d = next_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ----- dv/sorted_set_table_test.sv -----
// Testbench for sorted_set_table: directed and random set operations checked by a scoreboard.
`timescale 1ns / 100ps

module sorted_set_table_test;

  typedef struct packed {
    logic                        ok;
    logic [sst_pkg::VALUE_W-1:0] item;
    logic [sst_pkg::COUNT_W-1:0] count;
  } set_result_t;

  class set_scoreboard;
    logic [sst_pkg::VALUE_W-1:0] held [64];
    int                          held_count;
    int                          limit_reg;
    int                          peak;
    int                          checked;
    int                          errors;
    set_result_t                 expected_q [$];

    function new();
      held_count = 0;
      limit_reg  = 64;
      peak       = 0;
      checked    = 0;
      errors     = 0;
    endfunction

    function void set_limit(logic [sst_pkg::COUNT_W-1:0] m);
      limit_reg = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [sst_pkg::VALUE_W-1:0] pick_held();
      if (held_count == 0) return $urandom;
      return held[$urandom_range(0, held_count - 1)];
    endfunction

    function void note_input(sst_pkg::op_e op, logic [sst_pkg::VALUE_W-1:0] v,
                             logic [sst_pkg::INDEX_W-1:0] idx);
      set_result_t res;
      int          eff;
      int          r;
      int          k;
      bit          found;
      eff = (limit_reg > 64) ? 64 : limit_reg;
      r = 0;
      while (r < held_count && held[r] < v) r++;
      found = (r < held_count) && (held[r] == v);
      res = '0;
      case (op)
        sst_pkg::OP_INSERT: begin
          if (held_count < eff && !found) begin
            for (k = held_count; k > r; k--) held[k] = held[k-1];
            held[r] = v;
            held_count++;
            res.ok = 1'b1;
          end
        end
        sst_pkg::OP_ERASE: begin
          if (found) begin
            for (k = r; k + 1 < held_count; k++) held[k] = held[k+1];
            held_count--;
            res.ok = 1'b1;
          end
        end
        sst_pkg::OP_CONTAINS: res.ok = found;
        default: begin
          if (idx < held_count) begin
            res.item = held[idx];
            res.ok   = 1'b1;
          end
        end
      endcase
      res.count = sst_pkg::COUNT_W'(held_count);
      if (held_count > peak) peak = held_count;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic ok, logic [sst_pkg::VALUE_W-1:0] item,
                               logic [sst_pkg::COUNT_W-1:0] cnt);
      set_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding: ok %0d item %0h count %0d",
               ok, item, cnt);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (ok !== exp.ok) begin
        $error("ok mismatch: expected %0d actual %0d", exp.ok, ok);
        errors++;
      end
      if (item !== exp.item) begin
        $error("item_out mismatch: expected %0h actual %0h", exp.item, item);
        errors++;
      end
      if (cnt !== exp.count) begin
        $error("item_count mismatch: expected %0d actual %0d", exp.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [sst_pkg::COUNT_W-1:0] cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [sst_pkg::OP_W-1:0]    op_i;
  logic [sst_pkg::VALUE_W-1:0] value_i;
  logic [sst_pkg::INDEX_W-1:0] index_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic                        ok_o;
  logic [sst_pkg::VALUE_W-1:0] item_out_o;
  logic [sst_pkg::COUNT_W-1:0] item_count_o;

  set_scoreboard sb = new();
  bit            gaps_on;
  int            stall_pct;
  int            stall_left;
  int            items_sent;

  sorted_set_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .item_out_o  (item_out_o),
    .item_count_o(item_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL sorted_set_table");
    $finish;
  end

  // Random receiver stall bursts.
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(ok_o, item_out_o, item_count_o);
    end
  end

  task automatic send_item(input sst_pkg::op_e op, input logic [sst_pkg::VALUE_W-1:0] v,
                           input logic [sst_pkg::INDEX_W-1:0] idx);
    int gap;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= v;
    index_i    <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(op, v, idx);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [sst_pkg::COUNT_W-1:0] m);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_limit(m);
  endtask

  task automatic run_random(input int n, input int span, input int ins_pct);
    int                          k;
    int                          r;
    int                          top;
    sst_pkg::op_e                op;
    logic [sst_pkg::VALUE_W-1:0] v;
    logic [sst_pkg::INDEX_W-1:0] idx;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 199) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = sst_pkg::OP_INSERT;
      else if (r < ins_pct + (100 - ins_pct) / 3) op = sst_pkg::OP_ERASE;
      else if (r < ins_pct + 2 * (100 - ins_pct) / 3) op = sst_pkg::OP_CONTAINS;
      else op = sst_pkg::OP_GET;
      if ($urandom_range(0, 1)) v = sb.pick_held();
      else if (span == 0 || $urandom_range(0, 4) == 0) v = $urandom;
      else v = $urandom_range(0, span);
      top = (sb.held_count > 63) ? 63 : sb.held_count;
      if ($urandom_range(0, 9) < 7) idx = sst_pkg::INDEX_W'($urandom_range(0, top));
      else idx = sst_pkg::INDEX_W'($urandom_range(0, 63));
      send_item(op, v, idx);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i       = sst_pkg::OP_INSERT;
    value_i    = '0;
    index_i    = '0;
    gaps_on    = 1'b1;
    stall_pct  = 15;
    items_sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty set, extremes, duplicate and absent items, rank out of range.
    send_item(sst_pkg::OP_GET,      32'd0,        6'd0);
    send_item(sst_pkg::OP_CONTAINS, 32'd5,        6'd0);
    send_item(sst_pkg::OP_ERASE,    32'd5,        6'd0);
    send_item(sst_pkg::OP_INSERT,   32'd0,        6'd0);
    send_item(sst_pkg::OP_INSERT,   32'hFFFFFFFF, 6'd0);
    send_item(sst_pkg::OP_INSERT,   32'd0,        6'd0);
    send_item(sst_pkg::OP_INSERT,   32'd1000,     6'd0);
    send_item(sst_pkg::OP_INSERT,   32'd500,      6'd0);
    send_item(sst_pkg::OP_CONTAINS, 32'd0,        6'd0);
    send_item(sst_pkg::OP_CONTAINS, 32'hFFFFFFFF, 6'd0);
    send_item(sst_pkg::OP_CONTAINS, 32'd999,      6'd0);
    send_item(sst_pkg::OP_GET,      32'd0,        6'd0);
    send_item(sst_pkg::OP_GET,      32'd0,        6'd3);
    send_item(sst_pkg::OP_GET,      32'd0,        6'd4);
    send_item(sst_pkg::OP_GET,      32'hFFFFFFFF, 6'd63);
    send_item(sst_pkg::OP_ERASE,    32'd1000,     6'd0);
    send_item(sst_pkg::OP_ERASE,    32'd1000,     6'd0);

    // Limit below the count held.
    write_limit(7'd2);
    send_item(sst_pkg::OP_INSERT,   32'd7,        6'd0);
    send_item(sst_pkg::OP_ERASE,    32'd500,      6'd0);
    send_item(sst_pkg::OP_INSERT,   32'd7,        6'd0);
    send_item(sst_pkg::OP_ERASE,    32'd0,        6'd0);
    send_item(sst_pkg::OP_INSERT,   32'd7,        6'd0);

    // Limit zero.
    write_limit(7'd0);
    send_item(sst_pkg::OP_INSERT,   32'd9,        6'd0);
    send_item(sst_pkg::OP_GET,      32'd0,        6'd1);

    write_limit(7'd64);
    run_random(500, 0, 60);
    write_limit(7'd127);
    run_random(300, 200, 40);
    write_limit(7'd8);
    run_random(250, 30, 50);
    write_limit(7'd1);
    run_random(150, 5, 50);
    write_limit(7'd0);
    run_random(100, 50, 50);
    write_limit(7'd20);
    run_random(300, 1000, 45);

    write_limit(7'd64);
    gaps_on   = 1'b0;
    stall_pct = 0;
    run_random(300, 100, 55);

    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d transactions, checked %0d results, peak count %0d.",
             items_sent, sb.checked, sb.peak);
    $display("Limits 0, 1, 2, 8, 20, 64 and 127 exercised with random sender and receiver idling.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS sorted_set_table");
    end else begin
      $display("FAIL sorted_set_table");
    end
    $finish;
  end

endmodule
